### hw/rtl/dth_pkg.sv
// Package for the decimal-text to hex-text converter.
// Character codes, result kinds, queue sizing and the command flag struct.
// No dependencies.
package dth_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NONE  = 8'h00;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // What the back end has to print for one queued command.
  typedef struct packed {
    logic emit_num;
    logic emit_stop;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'h0, nib};
    if (nib < 4'd10) hex_char = CH_ZERO + n8;
    else             hex_char = 8'h57 + n8;
  endfunction

endpackage

### hw/rtl/dth_front.sv
// Front end: accepts input beats, accumulates decimal digits and queues
// print/stop commands. Depends on dth_pkg.
module dth_front
  import dth_pkg::*;
#(
  parameter int VALUE_WIDTH    = 32,
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  in_char,
  input  logic                        end_of_input,
  output logic                        push,
  output cmd_flags_t                  push_flags,
  output logic [4*MAX_HEX_DIGITS-1:0] push_value
);

  localparam int PW = 4 * MAX_HEX_DIGITS;

  logic [VALUE_WIDTH-1:0]    acc;
  logic                      has_digits;
  logic                      stopped;
  logic                      is_digit;
  logic                      is_space;
  logic [VALUE_WIDTH-1:0]    acc_dig;
  logic [VALUE_WIDTH+PW-1:0] acc_wide;

  assign is_digit = !end_of_input && (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign is_space = !end_of_input && ((in_char == CH_SPACE) || (in_char == CH_NL));
  // acc*10 + digit as two shifts and two adds
  assign acc_dig  = (acc << 3) + (acc << 1) + VALUE_WIDTH'(in_char[3:0]);
  assign acc_wide = {{PW{1'b0}}, acc};

  assign push                 = accept && !stopped && !is_digit && (has_digits || !is_space);
  assign push_flags.emit_num  = has_digits;
  assign push_flags.emit_stop = !is_space;
  assign push_value           = acc_wide[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      has_digits <= 1'b0;
      stopped    <= 1'b0;
    end else if (accept && !stopped) begin
      if (is_digit) begin
        acc        <= acc_dig;
        has_digits <= 1'b1;
      end else begin
        acc        <= '0;
        has_digits <= 1'b0;
        stopped    <= !is_space;
      end
    end
  end

  ast_no_push_after_stop: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !push) else $error("command queued after stop");

endmodule

### hw/rtl/dth_queue.sv
// Short command queue between front and back end.
// Depends on dth_pkg for depth constants.
module dth_queue
  import dth_pkg::*;
#(
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          valid,
  output logic          full
);

  logic [DW-1:0]     mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign valid = (count != '0);
  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  ast_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop)) else $error("queue overflow");
  ast_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid) else $error("queue underflow");

endmodule

### hw/rtl/dth_back.sv
// Back end: pops commands and prints "0x", hex digits, newline and stop
// beats through a registered output stage. Depends on dth_pkg.
module dth_back
  import dth_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  cmd_flags_t                  q_flags,
  input  logic [4*MAX_HEX_DIGITS-1:0] q_value,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic                        m_tuser,
  output logic                        m_tlast
);

  localparam int PW = 4 * MAX_HEX_DIGITS;
  localparam int IW = (MAX_HEX_DIGITS > 1) ? $clog2(MAX_HEX_DIGITS) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_PFX0, ST_PFX1, ST_DIG, ST_NL, ST_STOP} state_t;

  state_t        state;
  logic [PW-1:0] val;
  logic [IW-1:0] idx;
  logic [IW-1:0] top;
  logic          stop_pend;
  logic          adv;

  assign adv = !m_tvalid || m_tready;
  assign pop = (state == ST_IDLE) && q_valid;

  // highest nonzero nibble of the incoming value, zero if none
  always_comb begin
    top = '0;
    for (int k = 0; k < MAX_HEX_DIGITS; k++) begin
      if (q_value[4*k +: 4] != 4'h0) top = IW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      stop_pend <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            val       <= q_value;
            idx       <= top;
            stop_pend <= q_flags.emit_stop;
            state     <= q_flags.emit_num ? ST_PFX0 : ST_STOP;
          end
        end
        ST_PFX0: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tdata  <= CH_ZERO;
            m_tuser  <= KIND_CHAR;
            m_tlast  <= 1'b0;
            state    <= ST_PFX1;
          end
        end
        ST_PFX1: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tdata  <= CH_X;
            m_tuser  <= KIND_CHAR;
            m_tlast  <= 1'b0;
            state    <= ST_DIG;
          end
        end
        ST_DIG: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tdata  <= hex_char(val[4*idx +: 4]);
            m_tuser  <= KIND_CHAR;
            m_tlast  <= 1'b0;
            if (idx == '0) state <= ST_NL;
            else           idx   <= idx - 1'b1;
          end
        end
        ST_NL: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tdata  <= CH_NL;
            m_tuser  <= KIND_CHAR;
            m_tlast  <= !stop_pend;
            state    <= stop_pend ? ST_STOP : ST_IDLE;
          end
        end
        ST_STOP: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tdata  <= CH_NONE;
            m_tuser  <= KIND_STOP;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ast_stop_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STOP) |-> m_tlast) else $error("stop beat not last");

endmodule

### hw/rtl/decimal_text_to_hex_text.sv
// Top level of the decimal-text to hex-text converter.
// Instantiates dth_front, dth_queue and dth_back; depends on dth_pkg.
//
// Reads a byte stream of decimal numbers separated by spaces or newlines and
// writes each number as "0x" plus lower-case hex digits without leading zeros,
// then a newline. Values wrap modulo 2^VALUE_WIDTH; only the low
// MAX_HEX_DIGITS nibbles are printed. End of input (s_tuser high) or any
// character other than a digit, space or newline prints the pending number
// and a stop beat (m_tuser high, m_tdata zero); all later input is taken and
// dropped. m_tlast marks the final beat caused by one input beat. The front
// end takes one input beat per cycle, digits included, while the 4-entry
// command queue has room. The back end pops a command only while idle and
// then writes its output beats in turn, holding while the sink stalls:
// 3 + n beats for an n-digit number, plus one stop beat when the command
// carries one. It takes no new command until the last beat is written.
// Output beats leave from a register, so a stalled sink holds the back end
// only, and input keeps flowing until the queue fills.
module decimal_text_to_hex_text
  import dth_pkg::*;
#(
  parameter int VALUE_WIDTH    = 32,
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tuser,   // [0] end_of_input
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tuser,   // [0] result_kind
  output logic       m_tlast    // last_of_run
);

  localparam int PW = 4 * MAX_HEX_DIGITS;
  localparam int DW = PW + FLAGS_W;

  logic          accept;
  logic          push;
  cmd_flags_t    push_flags;
  logic [PW-1:0] push_value;
  logic [DW-1:0] q_rdata;
  logic          q_valid;
  logic          q_full;
  logic          pop;
  cmd_flags_t    q_flags;
  logic [PW-1:0] q_value;

  // Hold input off only when the command queue cannot take another entry.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  dth_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_char     (s_tdata),
    .end_of_input(s_tuser),
    .push        (push),
    .push_flags  (push_flags),
    .push_value  (push_value)
  );

  dth_queue #(
    .DW(DW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({push_flags, push_value}),
    .pop  (pop),
    .rdata(q_rdata),
    .valid(q_valid),
    .full (q_full)
  );

  assign q_flags = cmd_flags_t'(q_rdata[DW-1:PW]);
  assign q_value = q_rdata[PW-1:0];

  dth_back #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_flags (q_flags),
    .q_value (q_value),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
